[rtl/ovp_pkg.sv]
// Shared types, constants and default sizes of the orthogonal volume projector.
`timescale 1ns / 1ps

package ovp_pkg;

  // Default limits of the volume and the width of the internal sums.
  localparam int MaxXDef     = 512;
  localparam int MaxZDef     = 256;
  localparam int MaxYDef     = 512;
  localparam int SumWidthDef = 48;

  // Fixed field widths of the stream items and the configuration port.
  localparam int VoxelW  = 32;
  localparam int IdxW    = 9;
  localparam int TotalW  = 48;
  localparam int CfgW    = 10;
  localparam int CfgIdxW = 2;
  localparam int SizeW   = 14;
  localparam int OutDataW = 72;

  // Result queue depth and the room kept free for items still in flight.
  localparam int ResFifoDepth = 16;
  localparam int MaxResPerItem = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSizeX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSizeZ = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSizeY = 2'd2;

  // Projection plane codes.
  localparam logic [1:0] PlaneYz = 2'd0;
  localparam logic [1:0] PlaneXz = 2'd1;
  localparam logic [1:0] PlaneXy = 2'd2;

  typedef struct packed {
    logic [1:0]        plane;
    logic [IdxW-1:0]   outer_index;
    logic [IdxW-1:0]   inner_index;
    logic [TotalW-1:0] total;
    logic              last;
  } result_t;

endpackage

[rtl/orthogonal_volume_projector.sv]
// Top level of the orthogonal volume projector: counters, sum pipeline and stores.
`timescale 1ns / 1ps

// Usage: voxels enter on the s_axis channel, one per transaction, with x
// running fastest, then z, then y slowest. Each voxel is added into three
// sums: a running row sum over x (a register), a per-x line sum over z (a
// line RAM of MAX_X entries) and a per-(z, x) plane sum over y (a plane RAM of
// MAX_Z * MAX_X entries). A YZ pixel leaves when an x row ends, an XZ pixel
// for every voxel of the last y frame and an XY pixel for every voxel of the
// last z row of a frame. The results of one voxel leave on m_axis in the
// order yz, xz, xy, and tlast marks the final one of them.
// Timing: a voxel is accepted at an edge, its stores are read at that edge,
// and at the next edge its sums are written back and its results enter a
// sixteen-entry result queue. The head of the queue drives m_axis directly,
// so a result shows once none waits ahead of it. One voxel is accepted per
// cycle; the rate drops only when the result queue fills, since a voxel may
// cause up to three results while m_axis moves one per cycle. A write-back
// meeting the read of the next voxel is forwarded from the pipeline register.
// Reset clears the counters, the pipeline and the queue and sets the sizes to
// their maximum; the RAMs need no clearing, since a sum restarts at the first
// element of each axis. When m_axis stalls, results wait in the queue and
// s_axis_tready falls once the queue lacks room for the voxels in flight.
// The user must write sizes on the cfg port only while idle; the block does not check.

module orthogonal_volume_projector
  import ovp_pkg::*;
#(
  parameter int MAX_X     = MaxXDef,
  parameter int MAX_Z     = MaxZDef,
  parameter int MAX_Y     = MaxYDef,
  parameter int SUM_WIDTH = SumWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // Voxel stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VoxelW-1:0]   s_axis_tdata,   // [31:0] voxel
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [8:0] outer_index, [17:9] inner_index,
                                              // [65:18] total, [71:66] zero
  output logic [1:0]          m_axis_tuser,   // [1:0] plane
  output logic                m_axis_tlast
);

  localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int PD  = MAX_Z * MAX_X;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
  localparam int LW  = $clog2(ResFifoDepth + 1);

  // A size of zero acts as one and a size above its limit acts as the limit.
  function automatic logic [SizeW-1:0] clamp_size(input logic [CfgW-1:0] v, input int max);
    logic [SizeW-1:0] ve;
    ve = SizeW'(v);
    if (ve == '0) begin
      return SizeW'(1);
    end else if (ve > SizeW'(max)) begin
      return SizeW'(max);
    end
    return ve;
  endfunction

  // Configuration registers. The z size register is one bit narrower than
  // the other two, so bit 9 of a z write is dropped.
  logic [CfgW-1:0] size_x_q, size_y_q;
  logic [8:0]      size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= CfgW'(512);
      size_z_q <= 9'(256);
      size_y_q <= CfgW'(512);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSizeX: size_x_q <= cfg_data_i;
        RegSizeZ: size_z_q <= cfg_data_i[8:0];
        RegSizeY: size_y_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  logic [SizeW-1:0] sx, sz, sy;
  assign sx = clamp_size(size_x_q, MAX_X);
  assign sz = clamp_size(CfgW'(size_z_q), MAX_Z);
  assign sy = clamp_size(size_y_q, MAX_Y);

  // Position counters of the next voxel.
  logic [XW-1:0] col_q;
  logic [ZW-1:0] row_q;
  logic [YW-1:0] frame_q;
  logic          end_x, end_z, end_y;
  logic          accept;

  assign end_x  = SizeW'(col_q) >= (sx - SizeW'(1));
  assign end_z  = SizeW'(row_q) >= (sz - SizeW'(1));
  assign end_y  = SizeW'(frame_q) >= (sy - SizeW'(1));
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      frame_q <= '0;
    end else if (accept) begin
      if (end_x) begin
        col_q <= '0;
        if (end_z) begin
          row_q   <= '0;
          frame_q <= end_y ? '0 : frame_q + YW'(1);
        end else begin
          row_q <= row_q + ZW'(1);
        end
      end else begin
        col_q <= col_q + XW'(1);
      end
    end
  end

  // Store addresses of the incoming voxel.
  logic [31:0]    plane_addr32;
  logic [PAW-1:0] plane_addr;
  assign plane_addr32 = 32'(row_q) * 32'(MAX_X) + 32'(col_q);
  assign plane_addr   = plane_addr32[PAW-1:0];

  // Pipeline register between the store read and the write-back.
  logic                 s1_valid_q;
  logic [SUM_WIDTH-1:0] s1_v_q;
  logic [XW-1:0]        s1_x_q;
  logic [ZW-1:0]        s1_z_q;
  logic [YW-1:0]        s1_y_q;
  logic [PAW-1:0]       s1_paddr_q;
  logic                 s1_end_x_q, s1_end_z_q, s1_end_y_q;
  logic                 fwd_line_q, fwd_plane_q;
  logic [SUM_WIDTH-1:0] fwd_line_data_q, fwd_plane_data_q;
  logic [SUM_WIDTH-1:0] row_sum_q;

  logic [SUM_WIDTH-1:0] line_rdata, plane_rdata;
  logic [SUM_WIDTH-1:0] line_old, plane_old;
  logic [SUM_WIDTH-1:0] row_sum, line_sum, plane_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_v_q      <= SUM_WIDTH'($signed(s_axis_tdata));
      s1_x_q      <= col_q;
      s1_z_q      <= row_q;
      s1_y_q      <= frame_q;
      s1_paddr_q  <= plane_addr;
      s1_end_x_q  <= end_x;
      s1_end_z_q  <= end_z;
      s1_end_y_q  <= end_y;
      // The voxel ahead writes its sums at this very edge, after the read.
      fwd_line_q       <= s1_valid_q && (s1_x_q == col_q);
      fwd_plane_q      <= s1_valid_q && (s1_paddr_q == plane_addr);
      fwd_line_data_q  <= line_sum;
      fwd_plane_data_q <= plane_sum;
    end
    if (s1_valid_q) begin
      row_sum_q <= row_sum;
    end
  end

  assign line_old  = fwd_line_q ? fwd_line_data_q : line_rdata;
  assign plane_old = fwd_plane_q ? fwd_plane_data_q : plane_rdata;

  // Each sum restarts from the voxel at the first element of its axis.
  assign row_sum   = ((s1_x_q == '0) ? '0 : row_sum_q) + s1_v_q;
  assign plane_sum = ((s1_y_q == '0) ? '0 : plane_old) + s1_v_q;
  assign line_sum  = ((s1_z_q == '0) ? '0 : line_old) + s1_v_q;

  ovp_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (MAX_X)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_x_q),
    .wdata_i (line_sum),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  ovp_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (PD)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_paddr_q),
    .wdata_i (plane_sum),
    .re_i    (accept),
    .raddr_i (plane_addr),
    .rdata_o (plane_rdata)
  );

  // Build the results of the voxel in the write-back stage.
  logic [31:0]         x32, z32, y32;
  logic [63:0]         row64, plane64, line64;
  result_t             res_all [MaxResPerItem];
  logic [2:0]          res_en;
  result_t             push_data [MaxResPerItem];
  logic [1:0]          push_cnt;

  assign x32     = 32'(s1_x_q);
  assign z32     = 32'(s1_z_q);
  assign y32     = 32'(s1_y_q);
  assign row64   = 64'(row_sum);
  assign plane64 = 64'(plane_sum);
  assign line64  = 64'(line_sum);

  always_comb begin
    res_all[0] = '{plane: PlaneYz, outer_index: z32[IdxW-1:0], inner_index: y32[IdxW-1:0],
                   total: row64[TotalW-1:0], last: 1'b0};
    res_all[1] = '{plane: PlaneXz, outer_index: z32[IdxW-1:0], inner_index: x32[IdxW-1:0],
                   total: plane64[TotalW-1:0], last: 1'b0};
    res_all[2] = '{plane: PlaneXy, outer_index: y32[IdxW-1:0], inner_index: x32[IdxW-1:0],
                   total: line64[TotalW-1:0], last: 1'b0};
    res_en = {s1_end_z_q, s1_end_y_q, s1_end_x_q} & {3{s1_valid_q}};

    for (int k = 0; k < MaxResPerItem; k++) begin
      push_data[k] = res_all[k];
    end
    push_cnt = 2'd0;
    for (int k = 0; k < MaxResPerItem; k++) begin
      if (res_en[k]) begin
        push_data[push_cnt] = res_all[k];
        push_cnt = push_cnt + 2'd1;
      end
    end
    if (push_cnt != 2'd0) begin
      push_data[push_cnt - 2'd1].last = 1'b1;
    end
  end

  // Result queue toward m_axis.
  result_t        head;
  logic [LW-1:0]  level;
  logic [LW+1:0]  need;

  ovp_result_fifo #(
    .DEPTH (ResFifoDepth)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (push_data),
    .pop_i       (m_axis_tready),
    .head_o      (head),
    .valid_o     (m_axis_tvalid),
    .level_o     (level)
  );

  // Keep room for the voxel in the write-back stage and the one accepted now.
  assign need = (LW + 2)'(level) + (s1_valid_q ? (LW + 2)'(MaxResPerItem) : '0);
  assign s_axis_tready = need <= (LW + 2)'(ResFifoDepth - MaxResPerItem);

  assign m_axis_tdata = {(OutDataW - 2 * IdxW - TotalW)'(0), head.total,
                         head.inner_index, head.outer_index};
  assign m_axis_tuser = head.plane;
  assign m_axis_tlast = head.last;

  // The result queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LW'(ResFifoDepth))
    else $error("result queue overflow");

  // An accepted voxel is in the write-back stage at the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted voxel lost before write-back");

  // A voxel that ends an x row always pushes at least its yz result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_end_x_q) |-> (push_cnt != 2'd0))
    else $error("row end without a result");

  // Counters stay inside the stores.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < 32'(MAX_X)) && (32'(row_q) < 32'(MAX_Z)) && (32'(frame_q) < 32'(MAX_Y)))
    else $error("position counter out of range");

endmodule

[rtl/ovp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ovp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ovp_result_fifo.sv]
// Result queue that takes up to three results per cycle and hands out one.
`timescale 1ns / 1ps

module ovp_result_fifo
  import ovp_pkg::*;
#(
  parameter int DEPTH = ResFifoDepth,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  result_t       push_data_i [MaxResPerItem],
  input  logic          pop_i,
  output result_t       head_o,
  output logic          valid_o,
  output logic [CW-1:0] level_o
);

  result_t       mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] level_q, level_d;
  logic          do_pop;

  assign do_pop = pop_i && (level_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q + AW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + AW'(do_pop);
    level_d  = level_q + CW'(push_cnt_i) - CW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResPerItem; k++) begin
      if (k < int'(push_cnt_i)) begin
        mem_q[wr_ptr_q + AW'(k)] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (level_q != '0);
  assign level_o = level_q;

endmodule
